FILE: rtl/ipv4f_pkg.sv
// Shared types, codes and constants for the IPv4 receive header filter.
// No dependencies; every other file imports this package.
`default_nettype none

package ipv4f_pkg;

	localparam int APB_ADDR_W = 4;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 80;

	localparam logic [4:0]  HDR_LAST_POS = 5'd19;
	localparam logic [15:0] HDR_BYTES    = 16'd20;
	localparam logic [15:0] CSUM_GOOD    = 16'hffff;
	localparam logic [7:0]  VER_IHL      = 8'h45;
	localparam logic [7:0]  FLAG_MASK    = 8'hbf;
	localparam logic [3:0]  MCAST_NIBBLE = 4'he;
	localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;

	typedef enum logic [1:0] {
		REG_LOCAL_ADDR = 2'd0,
		REG_BCAST_ADDR = 2'd1,
		REG_ICMP_EN    = 2'd2,
		REG_TCP_EN     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERDICT_DROP = 2'd0,
		VERDICT_ICMP = 2'd1,
		VERDICT_TCP  = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		RSN_NONE     = 3'd0,
		RSN_CHECKSUM = 3'd1,
		RSN_VERSION  = 3'd2,
		RSN_LENGTH   = 3'd3,
		RSN_FRAGMENT = 3'd4,
		RSN_NOT_OURS = 3'd5,
		RSN_PROTOCOL = 3'd6
	} reason_t;

	typedef enum logic [1:0] {
		CLS_OURS  = 2'd0,
		CLS_BCAST = 2'd1,
		CLS_MCAST = 2'd2,
		CLS_OTHER = 2'd3
	} addr_class_t;

	typedef struct packed {
		logic [31:0] local_addr;
		logic [31:0] bcast_addr;
		logic        icmp_en;
		logic        tcp_en;
	} cfg_t;

	// Everything the verdict logic needs from one finished header
	typedef struct packed {
		logic [15:0] csum;
		logic [15:0] psum;
		logic [7:0]  version_ihl;
		logic [15:0] total_length;
		logic [15:0] payload_length;
		logic [15:0] frame_limit;
		logic [7:0]  flags_high;
		logic [7:0]  fragment_low;
		logic [7:0]  protocol;
		logic [31:0] source;
		logic [31:0] dest;
	} hdr_rec_t;

	// 16-bit add with end-around carry
	function automatic logic [15:0] add_eac(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/ipv4f_cfg_regs.sv
// APB register file: local and broadcast addresses, ICMP and TCP enables.
// Depends on ipv4f_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module ipv4f_cfg_regs
	import ipv4f_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_addr <= '0;
			cfg_q.bcast_addr <= ALL_ONES;
			cfg_q.icmp_en    <= 1'b0;
			cfg_q.tcp_en     <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_LOCAL_ADDR: cfg_q.local_addr <= pwdata;
				REG_BCAST_ADDR: cfg_q.bcast_addr <= pwdata;
				REG_ICMP_EN:    cfg_q.icmp_en    <= pwdata[0];
				REG_TCP_EN:     cfg_q.tcp_en     <= pwdata[0];
				default:        cfg_q.tcp_en     <= cfg_q.tcp_en;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LOCAL_ADDR: prdata = cfg_q.local_addr;
			REG_BCAST_ADDR: prdata = cfg_q.bcast_addr;
			REG_ICMP_EN:    prdata = {31'd0, cfg_q.icmp_en};
			REG_TCP_EN:     prdata = {31'd0, cfg_q.tcp_en};
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/ipv4f_hdr_parse.sv
// Byte-wise header parser: running checksum and pseudo-header sums, field
// capture, and the finished-header record register. Depends on ipv4f_pkg.
`default_nettype none

module ipv4f_hdr_parse
	import ipv4f_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_acc,
	input  wire logic [7:0]  header_byte,
	input  wire logic        first_byte,
	input  wire logic [15:0] frame_length,
	input  wire logic        rec_take,
	output hdr_rec_t         rec,
	output logic             rec_valid
);

	localparam logic [4:0] POS_VER     = 5'd0;
	localparam logic [4:0] POS_TLEN_HI = 5'd2;
	localparam logic [4:0] POS_TLEN_LO = 5'd3;
	localparam logic [4:0] POS_PLEN    = 5'd4;
	localparam logic [4:0] POS_FLAGS   = 5'd6;
	localparam logic [4:0] POS_FRAG    = 5'd7;
	localparam logic [4:0] POS_PROTO   = 5'd9;
	localparam logic [4:0] POS_SRC_HI  = 5'd13;
	localparam logic [4:0] POS_SRC_LO  = 5'd15;
	localparam logic [4:0] POS_DST_HI  = 5'd17;
	localparam logic [4:0] POS_SRC_0   = 5'd12;
	localparam logic [4:0] POS_SRC_3   = 5'd15;
	localparam logic [4:0] POS_DST_0   = 5'd16;

	logic [4:0]  count_q;
	logic [15:0] sum_q;
	logic [15:0] psum_q;
	logic [7:0]  hold_q;
	logic [7:0]  ver_q;
	logic [7:0]  tlen_hi_q;
	logic [15:0] tlen_q;
	logic [15:0] plen_q;
	logic [7:0]  flags_q;
	logic [7:0]  frag_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] limit_q;
	hdr_rec_t    rec_s1;
	logic        rec_valid_s1;

	logic        active;
	logic        take;
	logic        last;
	logic [4:0]  pos;
	logic [15:0] word;
	logic [15:0] tlen_now;
	logic [15:0] plen_now;
	logic [15:0] sum_next;
	logic [15:0] psum_word;
	logic        psum_add;
	logic [15:0] psum_next;

	assign active   = first_byte | (count_q != 5'd0);
	assign take     = byte_acc & active;
	assign pos      = first_byte ? POS_VER : count_q;
	assign last     = take & (pos == HDR_LAST_POS);
	assign word     = {hold_q, header_byte};
	assign tlen_now = {tlen_hi_q, header_byte};
	assign plen_now = (tlen_now >= HDR_BYTES) ? (tlen_now - HDR_BYTES) : 16'd0;

	always_comb begin
		if (pos == POS_VER) begin
			sum_next = '0;
		end else if (pos[0]) begin
			sum_next = add_eac(sum_q, word);
		end else begin
			sum_next = sum_q;
		end
	end

	// Fold each pseudo-header word in as soon as it is complete
	always_comb begin
		psum_add  = 1'b1;
		psum_word = word;
		priority if (pos == POS_PLEN) begin
			psum_word = plen_q;
		end else if (pos == POS_PROTO) begin
			psum_word = {8'd0, header_byte};
		end else if (pos == POS_SRC_HI || pos == POS_SRC_LO || pos == POS_DST_HI
				|| pos == HDR_LAST_POS) begin
			psum_word = word;
		end else begin
			psum_add = 1'b0;
		end
	end

	always_comb begin
		if (pos == POS_VER) begin
			psum_next = '0;
		end else if (psum_add) begin
			psum_next = add_eac(psum_q, psum_word);
		end else begin
			psum_next = psum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take) begin
			count_q <= last ? 5'd0 : pos + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sum_q  <= sum_next;
			psum_q <= psum_next;
			if (!pos[0]) begin
				hold_q <= header_byte;
			end
			if (first_byte) begin
				limit_q <= frame_length;
			end
			unique case (pos)
				POS_VER:     ver_q     <= header_byte;
				POS_TLEN_HI: tlen_hi_q <= header_byte;
				POS_TLEN_LO: begin
					tlen_q <= tlen_now;
					plen_q <= plen_now;
				end
				POS_FLAGS:   flags_q   <= header_byte;
				POS_FRAG:    frag_q    <= header_byte;
				POS_PROTO:   proto_q   <= header_byte;
				default:     ;
			endcase
			if (pos >= POS_SRC_0 && pos <= POS_SRC_3) begin
				src_q <= {src_q[23:0], header_byte};
			end
			if (pos >= POS_DST_0) begin
				dst_q <= {dst_q[23:0], header_byte};
			end
		end
	end

	// Record register: hold one finished header until the verdict stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s1 <= 1'b0;
		end else if (last) begin
			rec_valid_s1 <= 1'b1;
		end else if (rec_take) begin
			rec_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last) begin
			rec_s1.csum           <= sum_next;
			rec_s1.psum           <= psum_next;
			rec_s1.version_ihl    <= ver_q;
			rec_s1.total_length   <= tlen_q;
			rec_s1.payload_length <= plen_q;
			rec_s1.frame_limit    <= limit_q;
			rec_s1.flags_high     <= flags_q;
			rec_s1.fragment_low   <= frag_q;
			rec_s1.protocol       <= proto_q;
			rec_s1.source         <= src_q;
			rec_s1.dest           <= {dst_q[23:0], header_byte};
		end
	end

	assign rec       = rec_s1;
	assign rec_valid = rec_valid_s1;

endmodule

`default_nettype wire

FILE: rtl/ipv4f_verdict.sv
// Verdict stage: address class, drop reason and routing from one header
// record, into the result register. Depends on ipv4f_pkg.
`default_nettype none

module ipv4f_verdict
	import ipv4f_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  cfg_t                       cfg,
	input  hdr_rec_t                   rec,
	input  wire logic                  rec_valid,
	output logic                       rec_take,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata
);

	addr_class_t cls;
	verdict_t    verdict;
	reason_t     reason;

	logic        out_valid_q;
	verdict_t    verdict_q;
	reason_t     reason_q;
	addr_class_t cls_q;
	logic [31:0] source_q;
	logic [7:0]  proto_q;
	logic [15:0] plen_q;
	logic [15:0] psum_q;

	always_comb begin
		priority if (rec.dest == cfg.local_addr) begin
			cls = CLS_OURS;
		end else if (rec.dest == cfg.bcast_addr || rec.dest == ALL_ONES) begin
			cls = CLS_BCAST;
		end else if (rec.dest[31:28] == MCAST_NIBBLE) begin
			cls = CLS_MCAST;
		end else begin
			cls = CLS_OTHER;
		end
	end

	always_comb begin
		verdict = VERDICT_DROP;
		priority if (rec.csum != CSUM_GOOD) begin
			reason = RSN_CHECKSUM;
		end else if (rec.version_ihl != VER_IHL) begin
			reason = RSN_VERSION;
		end else if (rec.total_length < HDR_BYTES || rec.total_length > rec.frame_limit) begin
			reason = RSN_LENGTH;
		end else if ((rec.flags_high & FLAG_MASK) != 8'd0 || rec.fragment_low != 8'd0) begin
			reason = RSN_FRAGMENT;
		end else if (cls == CLS_OTHER) begin
			reason = RSN_NOT_OURS;
		end else if (rec.protocol == PROTO_ICMP && cfg.icmp_en
				&& (cls == CLS_OURS || cls == CLS_BCAST)) begin
			reason  = RSN_NONE;
			verdict = VERDICT_ICMP;
		end else if (rec.protocol == PROTO_TCP && cfg.tcp_en && cls == CLS_OURS) begin
			reason  = RSN_NONE;
			verdict = VERDICT_TCP;
		end else begin
			reason = RSN_PROTOCOL;
		end
	end

	// Load when the result register is empty or its transaction completes
	assign rec_take = rec_valid & (~out_valid_q | m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rec_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_take) begin
			verdict_q <= verdict;
			reason_q  <= reason;
			cls_q     <= cls;
			source_q  <= rec.source;
			proto_q   <= rec.protocol;
			plen_q    <= rec.payload_length;
			psum_q    <= rec.psum;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, psum_q, plen_q, proto_q, source_q, cls_q, reason_q, verdict_q};

endmodule

`default_nettype wire

FILE: rtl/ipv4_rx_header_filter.sv
// IPv4 receive header filter: one header byte per cycle in, one verdict per header out.
// Throughput: one byte accepted every cycle; input stalls only while both the header
// record and the result register hold undelivered results.
// After the edge that accepts the twentieth header byte, the result goes to the record
// register, then to the result register (m_tvalid) once that register is free.
// Reset (arst_n low, asynchronous): parser idle, no result pending, registers at defaults.
`default_nettype none

module ipv4_rx_header_filter
	import ipv4f_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// tdata: header_byte [7:0], frame_length [23:8]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// tuser: first_byte
	input  wire logic                  s_tuser,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// tdata: verdict [1:0], drop_reason [4:2], address_class [6:5],
	// source_address [38:7], protocol [46:39], payload_length [62:47],
	// pseudo_sum [78:63], zero [79]
	output logic      [OUT_DATA_W-1:0] m_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	cfg_t     cfg;
	hdr_rec_t rec;
	logic     rec_valid;
	logic     rec_take;
	logic     byte_acc;

	// Stall while both the record register and the result register hold a result
	assign s_tready = ~(rec_valid & m_tvalid);
	assign byte_acc = s_tvalid & s_tready;

	ipv4f_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ipv4f_hdr_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_acc     (byte_acc),
		.header_byte  (s_tdata[7:0]),
		.first_byte   (s_tuser),
		.frame_length (s_tdata[23:8]),
		.rec_take     (rec_take),
		.rec          (rec),
		.rec_valid    (rec_valid)
	);

	ipv4f_verdict u_verdict (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rec       (rec),
		.rec_valid (rec_valid),
		.rec_take  (rec_take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

FILE: tb/ipv4_rx_header_filter_checker.sv
// Checker for the IPv4 receive header filter: watches the byte stream, the verdict
// stream and the APB port, predicts each verdict and compares it field by field.
// Depends on ipv4f_pkg for codes, widths and header constants.

module ipv4_rx_header_filter_checker
	import ipv4f_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	input  wire logic [31:0]           prdata,
	input  wire logic                  pready,
	output int                         fail_count,
	output int                         pending
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		verdict_t    verdict;
		reason_t     reason;
		addr_class_t addr_class;
		logic [31:0] source;
		logic [7:0]  protocol;
		logic [15:0] payload_length;
		logic [15:0] pseudo_sum;
	} header_verdict_t;

	header_verdict_t verdict_queue[$];

	// register copies
	logic [31:0] cfg_local;
	logic [31:0] cfg_bcast;
	logic        cfg_icmp;
	logic        cfg_tcp;

	// parser copy
	logic [4:0]  hdr_pos;
	logic [15:0] csum_acc;
	logic [7:0]  hi_hold;
	logic [7:0]  ver_ihl;
	logic [15:0] tot_len;
	logic [7:0]  flags_hi;
	logic [7:0]  frag_lo;
	logic [7:0]  proto;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] frame_lim;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic absorb_byte(input logic [7:0] b, input logic first, input logic [15:0] flen);
		logic [4:0]      pos;
		addr_class_t     cls;
		logic [15:0]     plen;
		logic [15:0]     psum;
		header_verdict_t v;
		if (first) begin
			hdr_pos = '0;
			csum_acc = '0;
			frame_lim = flen;
		end else if (hdr_pos == 0 || hdr_pos >= HDR_BYTES) begin
			// stray byte outside a header
			hdr_pos = '0;
			return;
		end
		pos = hdr_pos;
		case (pos)
			5'd0: ver_ihl = b;
			5'd2: tot_len = {b, 8'h00};
			5'd3: tot_len[7:0] = b;
			5'd6: flags_hi = b;
			5'd7: frag_lo = b;
			5'd9: proto = b;
			default: ;
		endcase
		if (pos >= 12 && pos <= 15)
			src_addr = {src_addr[23:0], b};
		if (pos >= 16 && pos <= 19)
			dst_addr = {dst_addr[23:0], b};
		if (!pos[0])
			hi_hold = b;
		else
			csum_acc = ones_add(csum_acc, {hi_hold, b});
		hdr_pos = pos + 5'd1;
		if (hdr_pos < HDR_BYTES)
			return;
		hdr_pos = '0;

		if (dst_addr == cfg_local)
			cls = CLS_OURS;
		else if (dst_addr == cfg_bcast || dst_addr == ALL_ONES)
			cls = CLS_BCAST;
		else if (dst_addr[31:28] == MCAST_NIBBLE)
			cls = CLS_MCAST;
		else
			cls = CLS_OTHER;

		// saturate payload length for short total length
		plen = (tot_len >= HDR_BYTES) ? tot_len - HDR_BYTES : 16'd0;
		psum = ones_add(16'd0, src_addr[31:16]);
		psum = ones_add(psum, src_addr[15:0]);
		psum = ones_add(psum, dst_addr[31:16]);
		psum = ones_add(psum, dst_addr[15:0]);
		psum = ones_add(psum, {8'd0, proto});
		psum = ones_add(psum, plen);

		v.verdict = VERDICT_DROP;
		if (csum_acc != CSUM_GOOD)
			v.reason = RSN_CHECKSUM;
		else if (ver_ihl != VER_IHL)
			v.reason = RSN_VERSION;
		else if (tot_len < HDR_BYTES || tot_len > frame_lim)
			v.reason = RSN_LENGTH;
		else if ((flags_hi & FLAG_MASK) != 0 || frag_lo != 0)
			v.reason = RSN_FRAGMENT;
		else if (cls == CLS_OTHER)
			v.reason = RSN_NOT_OURS;
		else if (proto == PROTO_ICMP && cfg_icmp && (cls == CLS_OURS || cls == CLS_BCAST)) begin
			v.reason = RSN_NONE;
			v.verdict = VERDICT_ICMP;
		end else if (proto == PROTO_TCP && cfg_tcp && cls == CLS_OURS) begin
			v.reason = RSN_NONE;
			v.verdict = VERDICT_TCP;
		end else
			v.reason = RSN_PROTOCOL;

		v.addr_class = cls;
		v.source = src_addr;
		v.protocol = proto;
		v.payload_length = plen;
		v.pseudo_sum = psum;
		verdict_queue.push_back(v);
	endtask

	task automatic check_verdict(input logic [OUT_DATA_W-1:0] d);
		header_verdict_t want;
		if (verdict_queue.size() == 0) begin
			$error("verdict transaction with none expected: %0h", d);
			fail_count++;
			return;
		end
		want = verdict_queue.pop_front();
		compare_field("verdict", want.verdict, d[1:0]);
		compare_field("drop_reason", want.reason, d[4:2]);
		compare_field("address_class", want.addr_class, d[6:5]);
		compare_field("source_address", want.source, d[38:7]);
		compare_field("protocol", want.protocol, d[46:39]);
		compare_field("payload_length", want.payload_length, d[62:47]);
		compare_field("pseudo_sum", want.pseudo_sum, d[78:63]);
	endtask

	task automatic apb_transaction();
		reg_idx_t idx;
		idx = reg_idx_t'(paddr[3:2]);
		if (pwrite) begin
			case (idx)
				REG_LOCAL_ADDR: cfg_local = pwdata;
				REG_BCAST_ADDR: cfg_bcast = pwdata;
				REG_ICMP_EN:    cfg_icmp = pwdata[0];
				REG_TCP_EN:     cfg_tcp = pwdata[0];
			endcase
		end else begin
			case (idx)
				REG_LOCAL_ADDR: compare_field("prdata local_address", cfg_local, prdata);
				REG_BCAST_ADDR: compare_field("prdata broadcast_address", cfg_bcast, prdata);
				REG_ICMP_EN:    compare_field("prdata icmp_enable", {31'd0, cfg_icmp}, prdata);
				REG_TCP_EN:     compare_field("prdata tcp_enable", {31'd0, cfg_tcp}, prdata);
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_local = '0;
			cfg_bcast = ALL_ONES;
			cfg_icmp = 1'b0;
			cfg_tcp = 1'b0;
			hdr_pos = '0;
			csum_acc = '0;
			hi_hold = '0;
			ver_ihl = '0;
			tot_len = '0;
			flags_hi = '0;
			frag_lo = '0;
			proto = '0;
			src_addr = '0;
			dst_addr = '0;
			frame_lim = '0;
			verdict_queue.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_verdict(m_tdata);
			if (psel && penable && pready)
				apb_transaction();
			if (s_tvalid && s_tready)
				absorb_byte(s_tdata[7:0], s_tuser, s_tdata[23:8]);
			pending = verdict_queue.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the IPv4 receive header filter bench: clock, reset, header stimulus, APB
// setup and verdict. Depends on ipv4f_pkg, the RTL and ipv4_rx_header_filter_checker.

module testbench
	import ipv4f_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_ITEMS = 180;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	logic [31:0] cur_local;
	logic [31:0] cur_bcast;
	logic [7:0]  hdr[20];

	ipv4_rx_header_filter uut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ipv4_rx_header_filter_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// end the run when no transaction of any kind completes for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [31:0] local_addr, input logic [31:0] bcast_addr,
			input logic icmp_en, input logic tcp_en);
		cur_local = local_addr;
		cur_bcast = bcast_addr;
		apb_access(1'b1, REG_LOCAL_ADDR, local_addr);
		apb_access(1'b1, REG_BCAST_ADDR, bcast_addr);
		apb_access(1'b1, REG_ICMP_EN, {31'd0, icmp_en});
		apb_access(1'b1, REG_TCP_EN, {31'd0, tcp_en});
		apb_access(1'b0, REG_LOCAL_ADDR, '0);
		apb_access(1'b0, REG_BCAST_ADDR, '0);
		apb_access(1'b0, REG_ICMP_EN, '0);
		apb_access(1'b0, REG_TCP_EN, '0);
	endtask

	// hold off until every verdict is out and the pipeline has settled
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic send_item(input logic [7:0] b, input logic first, input logic [15:0] flen);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {flen, b};
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_header(input logic [15:0] flen, input int count);
		for (int i = 0; i < count; i++)
			send_item(hdr[i], i == 0, (i == 0) ? flen : 16'($urandom_range(65535)));
		items_sent += count;
	endtask

	task automatic build_header(input logic [7:0] vi, input logic [15:0] tl,
			input logic [7:0] fh, input logic [7:0] fl, input logic [7:0] pr,
			input logic [31:0] src, input logic [31:0] dst, input bit csum_ok);
		int unsigned s;
		logic [15:0] ck;
		hdr[0] = vi;
		hdr[1] = 8'($urandom);
		{hdr[2], hdr[3]} = tl;
		hdr[4] = 8'($urandom);
		hdr[5] = 8'($urandom);
		hdr[6] = fh;
		hdr[7] = fl;
		hdr[8] = 8'($urandom);
		hdr[9] = pr;
		hdr[10] = 8'h00;
		hdr[11] = 8'h00;
		{hdr[12], hdr[13], hdr[14], hdr[15]} = src;
		{hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
		s = 0;
		for (int i = 0; i < 20; i += 2)
			s += {hdr[i], hdr[i + 1]};
		while (s > 32'hffff)
			s = (s & 32'hffff) + (s >> 16);
		ck = ~s[15:0];
		if (!csum_ok)
			ck ^= 16'($urandom_range(16'hffff, 1));
		{hdr[10], hdr[11]} = ck;
	endtask

	task automatic directed_header(input logic [7:0] vi, input logic [15:0] tl,
			input logic [7:0] fh, input logic [7:0] fl, input logic [7:0] pr,
			input logic [31:0] dst, input bit csum_ok, input logic [15:0] flen);
		build_header(vi, tl, fh, fl, pr, $urandom, dst, csum_ok);
		send_header(flen, 20);
	endtask

	task automatic random_header(output logic [15:0] flen);
		logic [15:0] tl;
		logic [7:0]  vi;
		logic [7:0]  fh;
		logic [7:0]  fl;
		logic [7:0]  pr;
		logic [31:0] dst;
		flen = ($urandom_range(9) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(1500, 20));
		if (flen >= 20 && $urandom_range(99) < 85)
			tl = 16'($urandom_range(flen, 20));
		else if ($urandom_range(1) == 0)
			tl = 16'($urandom_range(19));
		else
			tl = 16'($urandom_range(65535));
		vi = ($urandom_range(99) < 92) ? VER_IHL : 8'($urandom);
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: fh = 8'h40;
			6, 7:             fh = 8'h00;
			default:          fh = 8'($urandom);
		endcase
		fl = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
		case ($urandom_range(9))
			0, 1, 2, 3: pr = PROTO_ICMP;
			4, 5, 6, 7: pr = PROTO_TCP;
			8:          pr = 8'd17;
			default:    pr = 8'($urandom);
		endcase
		case ($urandom_range(9))
			0, 1, 2, 3: dst = cur_local;
			4, 5:       dst = cur_bcast;
			6:          dst = ALL_ONES;
			7:          dst = {MCAST_NIBBLE, 28'($urandom)};
			default:    dst = $urandom;
		endcase
		build_header(vi, tl, fh, fl, pr, $urandom, dst, $urandom_range(99) < 90);
	endtask

	task automatic random_traffic(input int target);
		int start;
		int r;
		logic [15:0] flen;
		start = items_sent;
		while (items_sent - start < target) begin
			r = $urandom_range(99);
			if (r < 4) begin
				// stray or continuing byte without the start mark
				send_item(8'($urandom), 1'b0, 16'($urandom));
				items_sent++;
			end else if (r < 9) begin
				// abandoned header; the next start mark restarts parsing
				random_header(flen);
				send_header(flen, $urandom_range(19, 1));
			end else if (r < 12) begin
				for (int i = 0; i < 20; i++)
					hdr[i] = 8'($urandom);
				send_header(16'($urandom), 20);
			end else begin
				random_header(flen);
				send_header(flen, 20);
			end
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		configure(32'hc0a8_0105, 32'hc0a8_01ff, 1'b1, 1'b1);
		directed_header(VER_IHL, 16'd84, 8'h00, 8'h00, PROTO_ICMP, cur_local, 1, 16'd84);
		directed_header(VER_IHL, 16'd40, 8'h40, 8'h00, PROTO_TCP, cur_local, 1, 16'd1500);
		directed_header(VER_IHL, 16'd60, 8'h40, 8'h00, PROTO_ICMP, cur_bcast, 1, 16'd60);
		directed_header(VER_IHL, 16'd60, 8'h00, 8'h00, PROTO_ICMP, ALL_ONES, 1, 16'd64);
		directed_header(VER_IHL, 16'd40, 8'h40, 8'h00, PROTO_TCP, cur_bcast, 1, 16'd46);
		directed_header(VER_IHL, 16'd28, 8'h40, 8'h00, 8'd17, cur_local, 1, 16'd46);
		directed_header(VER_IHL, 16'd28, 8'h00, 8'h00, PROTO_ICMP, 32'he000_0001, 1, 16'd46);
		directed_header(VER_IHL, 16'd28, 8'h00, 8'h00, PROTO_ICMP, 32'h0a00_0001, 1, 16'd46);
		directed_header(VER_IHL, 16'd28, 8'h00, 8'h00, PROTO_ICMP, cur_local, 0, 16'd46);
		directed_header(8'h46, 16'd28, 8'h00, 8'h00, PROTO_ICMP, cur_local, 1, 16'd46);
		directed_header(VER_IHL, 16'd19, 8'h00, 8'h00, PROTO_TCP, cur_local, 1, 16'd46);
		directed_header(VER_IHL, 16'hffff, 8'h00, 8'h00, PROTO_TCP, cur_local, 1, 16'hffff);
		directed_header(VER_IHL, 16'd1501, 8'h00, 8'h00, PROTO_TCP, cur_local, 1, 16'd1500);
		directed_header(VER_IHL, 16'd20, 8'h00, 8'h00, PROTO_ICMP, cur_local, 1, 16'd0);
		directed_header(VER_IHL, 16'd28, 8'h20, 8'h00, PROTO_ICMP, cur_local, 1, 16'd46);
		directed_header(VER_IHL, 16'd28, 8'h80, 8'h00, PROTO_ICMP, cur_local, 1, 16'd46);
		directed_header(VER_IHL, 16'd28, 8'h00, 8'h01, PROTO_ICMP, cur_local, 1, 16'd46);
		directed_header(8'h00, 16'd0, 8'h00, 8'h00, 8'h00, 32'h0, 1, 16'd0);
		build_header(8'hff, 16'hffff, 8'hff, 8'hff, 8'hff, ALL_ONES, ALL_ONES, 1);
		send_header(16'hffff, 20);
		// stray byte while idle, a full header, then a header cut short and restarted
		send_item(8'hff, 1'b0, 16'hffff);
		items_sent++;
		directed_header(VER_IHL, 16'd84, 8'h00, 8'h00, PROTO_ICMP, cur_local, 1, 16'd84);
		send_header(16'd100, 9);
		directed_header(VER_IHL, 16'd40, 8'h40, 8'h00, PROTO_TCP, cur_local, 1, 16'd100);

		random_traffic(PHASE_ITEMS);
		drain();
		configure(32'h0000_0000, ALL_ONES, 1'b0, 1'b1);
		send_idle_pct = 45;
		random_traffic(PHASE_ITEMS);
		drain();
		configure(ALL_ONES, 32'h0000_0000, 1'b1, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 45;
		random_traffic(PHASE_ITEMS);
		drain();
		configure($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
		send_idle_pct = 15;
		recv_stall_pct = 15;
		random_traffic(PHASE_ITEMS);
		drain();

		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: ipv4_rx_header_filter.f
rtl/ipv4f_pkg.sv
rtl/ipv4f_cfg_regs.sv
rtl/ipv4f_hdr_parse.sv
rtl/ipv4f_verdict.sv
rtl/ipv4_rx_header_filter.sv
tb/ipv4_rx_header_filter_checker.sv
tb/testbench.sv
